// ===== rtl/core/h2nf_pkg.sv =====
package h2nf_pkg;

    localparam int DIM_DEFAULT = 64;

    localparam int W_OP     = 2;
    localparam int W_POS    = 6;
    localparam int W_SAMPLE = 16;
    localparam int W_COEF   = 28;
    localparam int W_CFG    = 3;

    localparam logic [W_CFG-1:0] LOG_SIDE_RST = 3'd6;

    typedef enum logic [W_OP-1:0] {
        OP_WRITE     = 2'd0,
        OP_TRANSFORM = 2'd1,
        OP_READ      = 2'd2
    } t_op;

    // Status and write strobes from the transform sequencer.
    typedef struct packed {
        logic busy;
        logic done;
        logic scr_we;
        logic coef_we;
    } t_seq_stat;

    // Enables for the three memories.
    typedef struct packed {
        logic smp_we;
        logic coef_re;
        logic scr_we;
        logic coef_we;
    } t_store_ctl;

endpackage

// ===== rtl/core/haar_2d_nonstandard_forward.sv =====
// Write items give no result; a read item gives its coefficient with the strobe
// in the cycle after it is accepted, one per cycle while busy is low.
// A transform on side 2^L holds busy while it runs: each 2x2 block takes four
// memory reads, a sum state and three coefficient writes, four on the last level
// (corner average). The done item is strobed in the cycle in which busy falls.
// Synchronous reset clears control and the side register (to 6); memories hold.
module haar_2d_nonstandard_forward #(
    parameter int DIM = h2nf_pkg::DIM_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [h2nf_pkg::W_OP-1:0]            i_operation,
    input  logic [h2nf_pkg::W_POS-1:0]           i_row,
    input  logic [h2nf_pkg::W_POS-1:0]           i_column,
    input  logic signed [h2nf_pkg::W_SAMPLE-1:0] i_sample,
    input  logic                                 i_cfg_we,
    input  logic [h2nf_pkg::W_CFG-1:0]           i_cfg_data,
    output logic                                 o_valid,
    output logic signed [h2nf_pkg::W_COEF-1:0]   o_coefficient,
    output logic                                 o_transform_done
);
    import h2nf_pkg::*;

    localparam int LD   = $clog2(DIM);
    localparam int SA_W = (DIM > 2) ? 2 * LD - 2 : 1;

    logic [W_CFG-1:0]         r_log_side;
    logic                     r_out_valid;
    logic                     r_out_done;

    logic                     acc;
    t_op                      op;
    logic                     is_write, is_read, is_xform;
    logic [W_CFG-1:0]         ls_c;
    logic [LD-1:0]            half0;
    logic [2*LD-1:0]          pos_addr;
    t_store_ctl               store_ctl;
    t_seq_stat                seq_stat;

    logic [2*LD-1:0]          smp_raddr;
    logic signed [W_SAMPLE-1:0] smp_rdata;
    logic [2*LD-1:0]          coef_waddr;
    logic signed [W_COEF-1:0] coef_wdata;
    logic signed [W_COEF-1:0] coef_rdata;
    logic [SA_W-1:0]          scr_raddr, scr_waddr;
    logic signed [W_COEF-1:0] scr_wdata, scr_rdata;

    assign acc      = start && !busy;
    assign op       = t_op'(i_operation);
    assign pos_addr = {i_row[LD-1:0], i_column[LD-1:0]};

    always_comb begin
        is_write = 1'b0;
        is_read  = 1'b0;
        is_xform = 1'b0;
        case (op)
            OP_WRITE:     is_write = acc;
            OP_TRANSFORM: is_xform = acc;
            OP_READ:      is_read  = acc;
            default: begin
            end
        endcase
    end

    // Side in use is clamped to 1..log2(DIM).
    always_comb begin
        if (r_log_side == '0) begin
            ls_c = W_CFG'(1);
        end else if (int'(r_log_side) > LD) begin
            ls_c = W_CFG'(LD);
        end else begin
            ls_c = r_log_side;
        end
    end
    assign half0 = LD'(1) << (ls_c - W_CFG'(1));

    assign store_ctl.smp_we  = is_write;
    assign store_ctl.coef_re = is_read;
    assign store_ctl.scr_we  = seq_stat.scr_we;
    assign store_ctl.coef_we = seq_stat.coef_we;

    h2nf_seq #(.DIM(DIM)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (is_xform),
        .i_half0      (half0),
        .i_smp_rdata  (smp_rdata),
        .i_scr_rdata  (scr_rdata),
        .o_smp_raddr  (smp_raddr),
        .o_scr_raddr  (scr_raddr),
        .o_scr_waddr  (scr_waddr),
        .o_scr_wdata  (scr_wdata),
        .o_coef_waddr (coef_waddr),
        .o_coef_wdata (coef_wdata),
        .o_stat       (seq_stat)
    );

    h2nf_store #(.DIM(DIM)) u_store (
        .i_clk        (i_clk),
        .i_ctl        (store_ctl),
        .i_smp_waddr  (pos_addr),
        .i_smp_wdata  (i_sample),
        .i_smp_raddr  (smp_raddr),
        .o_smp_rdata  (smp_rdata),
        .i_coef_waddr (coef_waddr),
        .i_coef_wdata (coef_wdata),
        .i_coef_raddr (pos_addr),
        .o_coef_rdata (coef_rdata),
        .i_scr_waddr  (scr_waddr),
        .i_scr_wdata  (scr_wdata),
        .i_scr_raddr  (scr_raddr),
        .o_scr_rdata  (scr_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_side  <= LOG_SIDE_RST;
            r_out_valid <= 1'b0;
            r_out_done  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_log_side <= i_cfg_data;
            end
            r_out_valid <= is_read || seq_stat.done;
            r_out_done  <= seq_stat.done;
        end
    end

    assign busy             = seq_stat.busy;
    assign o_valid          = r_out_valid;
    assign o_transform_done = r_out_done;
    assign o_coefficient    = r_out_done ? '0 : coef_rdata;

endmodule

// ===== rtl/core/h2nf_store.sv =====
module h2nf_store #(
    parameter int DIM = h2nf_pkg::DIM_DEFAULT
) (
    input  logic                                             i_clk,
    input  h2nf_pkg::t_store_ctl                             i_ctl,
    input  logic [2*$clog2(DIM)-1:0]                         i_smp_waddr,
    input  logic signed [h2nf_pkg::W_SAMPLE-1:0]             i_smp_wdata,
    input  logic [2*$clog2(DIM)-1:0]                         i_smp_raddr,
    output logic signed [h2nf_pkg::W_SAMPLE-1:0]             o_smp_rdata,
    input  logic [2*$clog2(DIM)-1:0]                         i_coef_waddr,
    input  logic signed [h2nf_pkg::W_COEF-1:0]               i_coef_wdata,
    input  logic [2*$clog2(DIM)-1:0]                         i_coef_raddr,
    output logic signed [h2nf_pkg::W_COEF-1:0]               o_coef_rdata,
    input  logic [((DIM > 2) ? 2*$clog2(DIM)-2 : 1)-1:0]     i_scr_waddr,
    input  logic signed [h2nf_pkg::W_COEF-1:0]               i_scr_wdata,
    input  logic [((DIM > 2) ? 2*$clog2(DIM)-2 : 1)-1:0]     i_scr_raddr,
    output logic signed [h2nf_pkg::W_COEF-1:0]               o_scr_rdata
);
    import h2nf_pkg::*;

    localparam int HALF      = DIM / 2;
    localparam int SMP_DEPTH = DIM * DIM;
    localparam int SCR_DEPTH = HALF * HALF;

    logic signed [W_SAMPLE-1:0] r_smp_mem  [SMP_DEPTH];
    logic signed [W_COEF-1:0]   r_coef_mem [SMP_DEPTH];
    logic signed [W_COEF-1:0]   r_scr_mem  [SCR_DEPTH];

    logic signed [W_SAMPLE-1:0] r_smp_rd;
    logic signed [W_COEF-1:0]   r_coef_rd;
    logic signed [W_COEF-1:0]   r_scr_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.smp_we) begin
            r_smp_mem[i_smp_waddr] <= i_smp_wdata;
        end
        r_smp_rd <= r_smp_mem[i_smp_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.coef_we) begin
            r_coef_mem[i_coef_waddr] <= i_coef_wdata;
        end
        if (i_ctl.coef_re) begin
            r_coef_rd <= r_coef_mem[i_coef_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.scr_we) begin
            r_scr_mem[i_scr_waddr] <= i_scr_wdata;
        end
        r_scr_rd <= r_scr_mem[i_scr_raddr];
    end

    assign o_smp_rdata  = r_smp_rd;
    assign o_coef_rdata = r_coef_rd;
    assign o_scr_rdata  = r_scr_rd;

endmodule

// ===== rtl/core/h2nf_seq.sv =====
module h2nf_seq #(
    parameter int DIM = h2nf_pkg::DIM_DEFAULT
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_go,
    input  logic [$clog2(DIM)-1:0]                           i_half0,
    input  logic signed [h2nf_pkg::W_SAMPLE-1:0]             i_smp_rdata,
    input  logic signed [h2nf_pkg::W_COEF-1:0]               i_scr_rdata,
    output logic [2*$clog2(DIM)-1:0]                         o_smp_raddr,
    output logic [((DIM > 2) ? 2*$clog2(DIM)-2 : 1)-1:0]     o_scr_raddr,
    output logic [((DIM > 2) ? 2*$clog2(DIM)-2 : 1)-1:0]     o_scr_waddr,
    output logic signed [h2nf_pkg::W_COEF-1:0]               o_scr_wdata,
    output logic [2*$clog2(DIM)-1:0]                         o_coef_waddr,
    output logic signed [h2nf_pkg::W_COEF-1:0]               o_coef_wdata,
    output h2nf_pkg::t_seq_stat                              o_stat
);
    import h2nf_pkg::*;

    localparam int LD   = $clog2(DIM);
    localparam int HALF = DIM / 2;
    localparam int F    = 2 * LD;
    localparam int SA_W = (DIM > 2) ? 2 * LD - 2 : 1;
    localparam int IJ_W = (LD > 1) ? LD - 1 : 1;
    localparam int W1   = W_COEF + 1;
    localparam int W2   = W_COEF + 2;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_SUM   = 4'b0100,
        ST_STORE = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [1:0]        r_ph, n_ph;
    logic [IJ_W-1:0]   r_i, n_i;
    logic [IJ_W-1:0]   r_j, n_j;
    logic [LD-1:0]     r_n, n_n;
    logic              r_first, n_first;

    logic signed [W_COEF-1:0] r_val [3];
    logic signed [W1-1:0]     r_s1, r_s2, r_d1, r_d2;

    logic [LD-1:0]            rd_row, rd_col;
    logic [LD-1:0]            wr_row, wr_col;
    logic signed [W_COEF-1:0] smp_ext;
    logic signed [W_COEF-1:0] cur;
    logic signed [W2-1:0]     avg_sum, c_x, c_y, c_sum;
    logic [1:0]               last_ph;
    logic                     i_last, j_last;

    // Quadrant order within a 2x2 block is a, b, c, d, one read per cycle.
    assign rd_row      = LD'({r_i, r_ph[1]});
    assign rd_col      = LD'({r_j, r_ph[0]});
    assign o_smp_raddr = {rd_row, rd_col};
    assign o_scr_raddr = SA_W'((int'(rd_row) % HALF) * HALF + (int'(rd_col) % HALF));

    // The first level works on samples scaled up to the coefficient format.
    assign smp_ext = W_COEF'(i_smp_rdata);
    assign cur     = r_first ? (smp_ext <<< F) : i_scr_rdata;

    // Store phases: 0 horizontal detail, 1 vertical detail, 2 diagonal detail,
    // 3 final average to the corner (last level only).
    assign avg_sum = W2'(r_s1) + W2'(r_s2);
    assign c_x     = r_ph[0] ? W2'(r_s1) : W2'(r_d1);
    assign c_y     = r_ph[0] ? W2'(r_s2) : W2'(r_d2);
    assign c_sum   = (r_ph[0] ^ r_ph[1]) ? (c_x - c_y) : (c_x + c_y);

    assign wr_row = (r_ph[0] ^ r_ph[1]) ? (r_n + LD'(r_i)) : LD'(r_i);
    assign wr_col = (!r_ph[0]) ? (r_n + LD'(r_j)) : LD'(r_j);

    assign o_coef_waddr = {wr_row, wr_col};
    assign o_coef_wdata = c_sum[W2-1:2];
    assign o_scr_waddr  = SA_W'(int'(r_i) * HALF + int'(r_j));
    assign o_scr_wdata  = avg_sum[W2-1:2];

    assign last_ph = (r_n == LD'(1)) ? 2'd3 : 2'd2;
    assign i_last  = (LD'(r_i) == r_n - LD'(1));
    assign j_last  = (LD'(r_j) == r_n - LD'(1));

    assign o_stat.busy    = (r_state != ST_IDLE);
    assign o_stat.done    = (r_state == ST_STORE) && (r_ph == 2'd3);
    assign o_stat.scr_we  = (r_state == ST_STORE) && (r_ph == 2'd0);
    assign o_stat.coef_we = (r_state == ST_STORE);

    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_i     = r_i;
        n_j     = r_j;
        n_n     = r_n;
        n_first = r_first;
        case (r_state)
            ST_IDLE: begin
                if (i_go) begin
                    n_state = ST_FETCH;
                    n_ph    = 2'd0;
                    n_i     = '0;
                    n_j     = '0;
                    n_n     = i_half0;
                    n_first = 1'b1;
                end
            end
            ST_FETCH: begin
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd3) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_state = ST_STORE;
                n_ph    = 2'd0;
            end
            ST_STORE: begin
                n_ph = r_ph + 2'd1;
                if (r_ph == last_ph) begin
                    n_ph = 2'd0;
                    if (r_n == LD'(1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        // Writes of this block are done before the next reads,
                        // so no scratch entry is read while its update is pending.
                        n_state = ST_FETCH;
                        if (j_last) begin
                            n_j = '0;
                            if (i_last) begin
                                n_i     = '0;
                                n_n     = r_n >> 1;
                                n_first = 1'b0;
                            end else begin
                                n_i = r_i + IJ_W'(1);
                            end
                        end else begin
                            n_j = r_j + IJ_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ph    <= 2'd0;
            r_i     <= '0;
            r_j     <= '0;
            r_n     <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_i     <= n_i;
            r_j     <= n_j;
            r_n     <= n_n;
            r_first <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FETCH) && (r_ph != 2'd0)) begin
            r_val[2'(r_ph - 2'd1)] <= cur;
        end
        if (r_state == ST_SUM) begin
            r_s1 <= W1'(r_val[0]) + W1'(r_val[1]);
            r_s2 <= W1'(r_val[2]) + W1'(cur);
            r_d1 <= W1'(r_val[0]) - W1'(r_val[1]);
            r_d2 <= W1'(r_val[2]) - W1'(cur);
        end
    end

endmodule

// ===== rtl/core/h2nf_chk.sv =====
module h2nf_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic [h2nf_pkg::W_OP-1:0]            i_operation,
    input logic                                 i_valid,
    input logic signed [h2nf_pkg::W_COEF-1:0]   i_coefficient,
    input logic                                 i_transform_done
);
    import h2nf_pkg::*;

    // A read item returns its data in the very next cycle.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_READ)) |=> (i_valid && !i_transform_done))
        else $error("read item without result in the next cycle");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_WRITE)) |=> !i_valid)
        else $error("write item produced a result");

    a_xform_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_TRANSFORM)) |=> (busy && !i_valid))
        else $error("transform item did not raise busy");

    // The acknowledge comes exactly when the transform releases the block.
    a_done_at_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (i_valid && i_transform_done && (i_coefficient == '0)))
        else $error("transform ended without a clean acknowledge");

endmodule

bind haar_2d_nonstandard_forward h2nf_chk u_h2nf_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_operation      (i_operation),
    .i_valid          (o_valid),
    .i_coefficient    (o_coefficient),
    .i_transform_done (o_transform_done)
);

// ===== verif/haar_2d_nonstandard_forward_checker.sv =====
module haar_2d_nonstandard_forward_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_busy,
    input  logic [h2nf_pkg::W_OP-1:0]            i_operation,
    input  logic [h2nf_pkg::W_POS-1:0]           i_row,
    input  logic [h2nf_pkg::W_POS-1:0]           i_column,
    input  logic signed [h2nf_pkg::W_SAMPLE-1:0] i_sample,
    input  logic                                 i_cfg_we,
    input  logic [h2nf_pkg::W_CFG-1:0]           i_cfg_data,
    input  logic                                 i_valid,
    input  logic signed [h2nf_pkg::W_COEF-1:0]   i_coefficient,
    input  logic                                 i_transform_done,
    output int                                   o_failures,
    output int                                   o_outstanding
);
    import h2nf_pkg::*;

    localparam int DIM     = DIM_DEFAULT;
    localparam int HALF    = DIM / 2;
    localparam int LOG_DIM = $clog2(DIM);
    localparam int FRAC    = 2 * LOG_DIM;

    typedef struct packed {
        logic signed [W_COEF-1:0] coefficient;
        logic                     transform_done;
    } t_coef_result;

    logic signed [W_SAMPLE-1:0] sample_mem [DIM*DIM];
    logic signed [W_COEF-1:0]   coef_mem [DIM*DIM];
    logic signed [W_COEF-1:0]   avg_mem [HALF*HALF];
    logic [W_CFG-1:0]           log_side;
    t_coef_result               pending_coefs [$];

    // The first level works on samples scaled up to the fixed point format,
    // later levels on the averages kept from the level before.
    function automatic longint level_input(bit first, int r, int c);
        if (first) begin
            return longint'(sample_mem[r*DIM + c]) * (longint'(1) << FRAC);
        end
        return longint'(avg_mem[r*HALF + c]);
    endfunction

    function automatic void decompose_matrix();
        int     lg;
        int     size;
        int     n;
        longint a;
        longint b;
        longint c;
        longint d;
        bit     first;
        lg = int'(log_side);
        if (lg < 1) begin
            lg = 1;
        end
        if (lg > LOG_DIM) begin
            lg = LOG_DIM;
        end
        size  = 1 << lg;
        first = 1'b1;
        while (size > 1) begin
            n = size / 2;
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n; j++) begin
                    a = level_input(first, 2*i, 2*j);
                    b = level_input(first, 2*i, 2*j + 1);
                    c = level_input(first, 2*i + 1, 2*j);
                    d = level_input(first, 2*i + 1, 2*j + 1);
                    avg_mem[i*HALF + j]         = W_COEF'((a + b + c + d) / 4);
                    coef_mem[i*DIM + n + j]     = W_COEF'((a - b + c - d) / 4);
                    coef_mem[(n+i)*DIM + j]     = W_COEF'((a + b - c - d) / 4);
                    coef_mem[(n+i)*DIM + n + j] = W_COEF'((a - b - c + d) / 4);
                end
            end
            first = 1'b0;
            size  = n;
        end
        coef_mem[0] = avg_mem[0];
    endfunction

    always @(posedge i_clk) begin
        t_coef_result want;
        t_coef_result entry;
        if (!i_rst_n) begin
            log_side = LOG_SIDE_RST;
            pending_coefs.delete();
        end else begin
            if (i_valid) begin
                if (pending_coefs.size() == 0) begin
                    o_failures++;
                    $display("%0t: unexpected result: coefficient %0d transform_done %0b",
                             $time, i_coefficient, i_transform_done);
                end else begin
                    want = pending_coefs.pop_front();
                    if (i_coefficient !== want.coefficient) begin
                        o_failures++;
                        $display("%0t: coefficient mismatch: expected %0d actual %0d",
                                 $time, want.coefficient, i_coefficient);
                    end
                    if (i_transform_done !== want.transform_done) begin
                        o_failures++;
                        $display("%0t: transform_done mismatch: expected %0b actual %0b",
                                 $time, want.transform_done, i_transform_done);
                    end
                end
            end
            if (i_cfg_we) begin
                log_side = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                case (i_operation)
                    OP_WRITE: begin
                        sample_mem[int'(i_row)*DIM + int'(i_column)] = i_sample;
                    end
                    OP_TRANSFORM: begin
                        decompose_matrix();
                        entry.coefficient    = '0;
                        entry.transform_done = 1'b1;
                        pending_coefs        = {pending_coefs, entry};
                    end
                    OP_READ: begin
                        entry.coefficient    = coef_mem[int'(i_row)*DIM + int'(i_column)];
                        entry.transform_done = 1'b0;
                        pending_coefs        = {pending_coefs, entry};
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_outstanding = pending_coefs.size();
    end

endmodule

// ===== verif/haar_2d_nonstandard_forward_tb.sv =====
module haar_2d_nonstandard_forward_tb;
    import h2nf_pkg::*;

    localparam int DIM          = DIM_DEFAULT;
    localparam int LOG_DIM      = $clog2(DIM);
    localparam int QUIET_LIMIT  = 50000;
    localparam int RANDOM_ITEMS = 1400;

    localparam logic [W_OP-1:0] OP_UNUSED = 2'd3;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [W_OP-1:0]            operation;
    logic [W_POS-1:0]           row;
    logic [W_POS-1:0]           column;
    logic signed [W_SAMPLE-1:0] sample;
    logic                       cfg_we;
    logic [W_CFG-1:0]           cfg_data;
    logic                       valid;
    logic signed [W_COEF-1:0]   coefficient;
    logic                       transform_done;

    int failures;
    int outstanding;
    int quiet;
    int fed_items;
    int side_log_now;
    int coef_extent;
    bit steady;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    haar_2d_nonstandard_forward #(
        .DIM(DIM)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (operation),
        .i_row           (row),
        .i_column        (column),
        .i_sample        (sample),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .o_valid         (valid),
        .o_coefficient   (coefficient),
        .o_transform_done(transform_done)
    );

    haar_2d_nonstandard_forward_checker coef_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_operation     (operation),
        .i_row           (row),
        .i_column        (column),
        .i_sample        (sample),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_valid         (valid),
        .i_coefficient   (coefficient),
        .i_transform_done(transform_done),
        .o_failures      (failures),
        .o_outstanding   (outstanding)
    );

    // A side-64 transform is the longest quiet stretch of a correct run.
    always @(posedge clk) begin
        if ((start && !busy) || valid || cfg_we) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic signed [W_SAMPLE-1:0] rand_sample();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return W_SAMPLE'($urandom_range(16) - 8);
            default: return W_SAMPLE'($urandom());
        endcase
    endfunction

    task automatic send_item(input logic [W_OP-1:0] op, input int r, input int c,
                             input logic signed [W_SAMPLE-1:0] s);
        int gap;
        if (!steady && $urandom_range(99) < 25) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(2, 4) : 1;
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        row       <= r[W_POS-1:0];
        column    <= c[W_POS-1:0];
        sample    <= s;
        do @(posedge clk); while (busy);
        if (op != OP_UNUSED) begin
            fed_items++;
        end
        if (op == OP_TRANSFORM && (1 << side_log_now) > coef_extent) begin
            coef_extent = 1 << side_log_now;
        end
    endtask

    // Reads stay inside the area that some transform has already filled.
    task automatic send_read();
        int lim;
        lim = coef_extent;
        if ($urandom_range(9) < 7 && (1 << side_log_now) < lim) begin
            lim = 1 << side_log_now;
        end
        send_item(OP_READ, $urandom_range(lim - 1), $urandom_range(lim - 1), rand_sample());
    endtask

    task automatic send_noise();
        send_item(($urandom_range(1) == 0) ? OP_UNUSED : OP_WRITE,
                  $urandom_range(DIM - 1), $urandom_range(DIM - 1), rand_sample());
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        // Writes give no result and may still be in flight.
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input int v);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= v[W_CFG-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        side_log_now = (v < 1) ? 1 : (v > LOG_DIM) ? LOG_DIM : v;
    endtask

    task automatic run_phase(input int cfg_value);
        int side;
        int roll;
        write_cfg(cfg_value);
        side = 1 << side_log_now;
        repeat ($urandom_range(2, 12)) begin
            if ($urandom_range(99) < 85) begin
                send_item(OP_WRITE, $urandom_range(side - 1), $urandom_range(side - 1),
                          rand_sample());
            end else begin
                send_noise();
            end
        end
        send_item(OP_TRANSFORM, $urandom_range(DIM - 1), $urandom_range(DIM - 1),
                  rand_sample());
        repeat ($urandom_range(8, 30)) begin
            roll = $urandom_range(99);
            if (roll < 60) begin
                send_read();
            end else if (roll < 80) begin
                send_item(OP_WRITE, $urandom_range(side - 1), $urandom_range(side - 1),
                          rand_sample());
            end else if (roll < 90) begin
                send_noise();
            end else begin
                send_item(OP_TRANSFORM, $urandom_range(DIM - 1), $urandom_range(DIM - 1),
                          rand_sample());
            end
        end
    endtask

    initial begin
        int phase;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        operation <= OP_WRITE;
        row       <= '0;
        column    <= '0;
        sample    <= '0;
        cfg_we    <= 1'b0;
        cfg_data  <= LOG_SIDE_RST;
        fed_items    = 0;
        side_log_now = int'(LOG_SIDE_RST);
        coef_extent  = 0;
        steady       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Smallest side with the sample extremes in one block.
        write_cfg(1);
        send_item(OP_WRITE, 0, 0, 16'sh7fff);
        send_item(OP_WRITE, 0, 1, 16'sh8000);
        send_item(OP_WRITE, 1, 0, 16'sh8000);
        send_item(OP_WRITE, 1, 1, 16'sh7fff);
        send_item(OP_TRANSFORM, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0);
        send_item(OP_READ, 0, 1, 0);
        send_item(OP_READ, 1, 0, 0);
        send_item(OP_READ, 1, 1, 0);
        send_item(OP_UNUSED, DIM - 1, DIM - 1, -1);
        // A write outside the side in use must not disturb the next transform,
        // and a write after a transform must not change its coefficients.
        send_item(OP_WRITE, DIM - 1, DIM - 1, 16'sh5555);
        send_item(OP_WRITE, 1, 1, -1);
        send_item(OP_READ, 1, 1, 0);
        // A side of zero is taken as the smallest side.
        write_cfg(0);
        send_item(OP_TRANSFORM, DIM - 1, 0, 0);
        send_item(OP_READ, 0, 0, 0);
        send_item(OP_READ, 1, 1, 0);

        // Fill the whole matrix once so that every later transform is defined.
        write_cfg(7);
        steady = 1'b1;
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                send_item(OP_WRITE, r, c, rand_sample());
            end
        end
        send_item(OP_TRANSFORM, 0, 0, 0);
        repeat (20) send_read();
        steady = 1'b0;

        fed_items = 0;
        phase     = 0;
        while (fed_items < RANDOM_ITEMS) begin
            steady = (phase >= 12 && phase < 18);
            if (phase < 8) begin
                run_phase(phase);
            end else if ($urandom_range(19) == 0) begin
                run_phase($urandom_range(5, 7));
            end else begin
                run_phase($urandom_range(0, 4));
            end
            phase++;
        end
        steady = 1'b0;

        drain_results();
        repeat (8) @(posedge clk);
        if (failures == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
